### rtl/smgos_pkg.sv
package smgos_pkg;

    // fixed sizes of the frame
    localparam int SAMPLE_BITS  = 24;
    localparam int WET_CHANNELS = 8;
    localparam int OUT_CHANNELS = 10;
    localparam int CH_W         = 3;

    // configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 25;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX_ALPHA  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_ALPHA = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE     = 2'd2;
    localparam int ACT_W = 4;
    localparam logic [ACT_W-1:0] ACT_RESET = 4'd10;

    // fixed-point constants
    localparam logic [24:0] ALPHA_ONE = 25'd16777216;
    localparam logic [16:0] MIX_ONE   = 17'd65536;
    localparam logic signed [15:0] DB_MIN = -16'sd24576;
    localparam logic signed [15:0] DB_MAX = 16'sd6144;
    localparam logic [21:0] LOG2_10_OVER_20 = 22'd2786635;

    // smoother state and shared multiplier
    localparam int STATE_W = 41;
    localparam int MUL_W   = 29;
    localparam int PROD_W  = 2 * MUL_W;

    typedef struct packed {
        logic signed [23:0] dry_left;
        logic signed [23:0] dry_right;
        logic [16:0]        mix_target;
        logic signed [15:0] gain_db_target;
        logic signed [23:0] wet_in_0;
        logic signed [23:0] wet_in_1;
        logic signed [23:0] wet_in_2;
        logic signed [23:0] wet_in_3;
        logic signed [23:0] wet_in_4;
        logic signed [23:0] wet_in_5;
        logic signed [23:0] wet_in_6;
        logic signed [23:0] wet_in_7;
    } t_in;

    typedef struct packed {
        logic signed [23:0] main_left;
        logic signed [23:0] main_right;
        logic signed [23:0] aux_out_0;
        logic signed [23:0] aux_out_1;
        logic signed [23:0] aux_out_2;
        logic signed [23:0] aux_out_3;
        logic signed [23:0] aux_out_4;
        logic signed [23:0] aux_out_5;
        logic signed [23:0] aux_out_6;
        logic signed [23:0] aux_out_7;
    } t_out;

    // 2^(i/16) in Q2.20, seventeen points
    function automatic logic [21:0] pow2_lut(input logic [4:0] idx);
        logic [21:0] v;
        case (idx)
            5'd0:    v = 22'd1048576;
            5'd1:    v = 22'd1095000;
            5'd2:    v = 22'd1143480;
            5'd3:    v = 22'd1194106;
            5'd4:    v = 22'd1246974;
            5'd5:    v = 22'd1302182;
            5'd6:    v = 22'd1359835;
            5'd7:    v = 22'd1420040;
            5'd8:    v = 22'd1482910;
            5'd9:    v = 22'd1548564;
            5'd10:   v = 22'd1617125;
            5'd11:   v = 22'd1688722;
            5'd12:   v = 22'd1763488;
            5'd13:   v = 22'd1841564;
            5'd14:   v = 22'd1923097;
            5'd15:   v = 22'd2008240;
            5'd16:   v = 22'd2097152;
            default: v = 22'd2097152;
        endcase
        return v;
    endfunction

endpackage

### rtl/smgos_mul.sv
module smgos_mul
    import smgos_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    // signed multiply with the product registered
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

### rtl/smoothed_mix_gain_output_stage_core.sv
// Smoothed dry/wet and dB gain output stage.
// Input channel: one frame per request on i_in_valid / o_in_ready with the
// payload in i_in_data. Output channel: one result per request on
// o_out_valid / i_out_ready with the payload in o_out_data.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 mix alpha, 1 gain alpha, 2 active outputs); write only while idle.
// Each frame runs through a single 29x29 multiplier under a sequencer:
// two partial products for each smoother, two for the dB-to-log2 product,
// one for the table interpolation, then two per aux channel.
// Frames do not overlap: the sequencer finishes one frame before it takes the next.
// o_in_ready is high only while the sequencer is idle.
// The finished result sits in an output register; a new frame is taken while
// it waits, and that frame's result holds in the final step until the
// receiver takes the previous one.
// Reset: alphas 1.0, ten active outputs, mix smoother fully wet, gain
// smoother at 0 dB, no result pending.
module smoothed_mix_gain_output_stage_core
    import smgos_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_MDIFF  = 5'd1;
    localparam logic [4:0] ST_MMHI   = 5'd2;
    localparam logic [4:0] ST_MMLO   = 5'd3;
    localparam logic [4:0] ST_MUPD   = 5'd4;
    localparam logic [4:0] ST_GDIFF  = 5'd5;
    localparam logic [4:0] ST_GMHI   = 5'd6;
    localparam logic [4:0] ST_GMLO   = 5'd7;
    localparam logic [4:0] ST_GUPD   = 5'd8;
    localparam logic [4:0] ST_YLO    = 5'd9;
    localparam logic [4:0] ST_YHI    = 5'd10;
    localparam logic [4:0] ST_YSUM   = 5'd11;
    localparam logic [4:0] ST_INTERP = 5'd12;
    localparam logic [4:0] ST_GAIN   = 5'd13;
    localparam logic [4:0] ST_CHA    = 5'd14;
    localparam logic [4:0] ST_CHB    = 5'd15;
    localparam logic [4:0] ST_LAST   = 5'd16;
    localparam logic [4:0] ST_DONE   = 5'd17;

    localparam logic [CH_W-1:0] CH_LAST = CH_W'(WET_CHANNELS - 1);
    localparam logic [41:0] SAT_POS = 42'd8388607;
    localparam logic [41:0] SAT_NEG = 42'd8388608;

    logic [4:0]  r_state, n_state;
    logic [24:0] r_mix_alpha, r_gain_alpha;
    logic [ACT_W-1:0] r_active;
    logic [STATE_W-1:0] r_mix_s;
    logic signed [STATE_W-1:0] r_gain_s;
    t_in  r_in;
    t_out r_out;
    logic r_out_valid;
    logic [41:0] r_mag;
    logic r_neg;
    logic [PROD_W-1:0] r_acc;
    logic [4:0]  r_n;
    logic [3:0]  r_i;
    logic [15:0] r_w;
    logic [24:0] r_gain;
    logic [CH_W-1:0] r_ch;
    logic r_sneg;
    logic signed [23:0] r_aux [WET_CHANNELS];

    logic in_acc, out_load;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic [PROD_W-1:0] prod_u;

    logic [24:0] ma, ga, alpha_sel;
    logic [16:0] mt_c;
    logic signed [15:0] gt_c;
    logic [STATE_W-1:0] mix_tgt;
    logic signed [STATE_W-1:0] gain_tgt;
    logic signed [42:0] diff;
    logic [42:0] diff_neg;
    logic [41:0] mag;
    logic [PROD_W-1:0] step;
    logic [63:0] u_sum;
    logic [21:0] lut_lo, lut_hi, lut_d, mant;
    logic [39:0] mant_w, gain_sh;
    logic signed [23:0] wet [WET_CHANNELS];
    logic signed [23:0] x_cur;
    logic [24:0] x_neg;
    logic [23:0] x_mag;
    logic [41:0] p_sat;
    logic signed [23:0] sat_val;
    logic [CH_W-1:0] st_idx;

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == ST_IDLE);
    assign out_load   = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign prod_u = mul_p;

    // wet samples of the frame as an array
    assign wet[0] = r_in.wet_in_0;
    assign wet[1] = r_in.wet_in_1;
    assign wet[2] = r_in.wet_in_2;
    assign wet[3] = r_in.wet_in_3;
    assign wet[4] = r_in.wet_in_4;
    assign wet[5] = r_in.wet_in_5;
    assign wet[6] = r_in.wet_in_6;
    assign wet[7] = r_in.wet_in_7;

    // clamped coefficients and targets
    always_comb begin
        ma = (r_mix_alpha > ALPHA_ONE) ? ALPHA_ONE : r_mix_alpha;
        ga = (r_gain_alpha > ALPHA_ONE) ? ALPHA_ONE : r_gain_alpha;
        mt_c = (r_in.mix_target > MIX_ONE) ? MIX_ONE : r_in.mix_target;
        if (r_in.gain_db_target < DB_MIN) begin
            gt_c = DB_MIN;
        end else if (r_in.gain_db_target > DB_MAX) begin
            gt_c = DB_MAX;
        end else begin
            gt_c = r_in.gain_db_target;
        end
        mix_tgt  = {mt_c, 24'd0};
        gain_tgt = {gt_c[15], gt_c, 24'd0};
    end

    // difference to target and its magnitude, shared by both smoothers
    always_comb begin
        if (r_state == ST_MDIFF) begin
            diff = $signed({2'b00, mix_tgt}) - $signed({2'b00, r_mix_s});
        end else begin
            diff = $signed({{2{gain_tgt[STATE_W-1]}}, gain_tgt})
                 - $signed({{2{r_gain_s[STATE_W-1]}}, r_gain_s});
        end
        diff_neg = -diff;
        mag = diff[42] ? diff_neg[41:0] : diff[41:0];
    end

    // smoother step from the two partial products
    assign step = r_acc + {24'd0, prod_u[PROD_W-1:24]};

    // log2 gain offset by sixteen, Q.56
    assign u_sum = {prod_u[39:0], 24'd0} + {6'd0, r_acc} + (64'd16 << 56);

    // table interpolation and exponent shift
    always_comb begin
        lut_lo = pow2_lut({1'b0, r_i});
        lut_hi = pow2_lut(5'({1'b0, r_i}) + 5'd1);
        lut_d  = lut_hi - lut_lo;
        mant   = lut_lo + prod_u[37:16];
        mant_w = {18'd0, mant};
        if (r_n >= 5'd16) begin
            gain_sh = mant_w << (r_n - 5'd16);
        end else begin
            gain_sh = mant_w >> (5'd16 - r_n);
        end
    end

    // current wet sample magnitude
    always_comb begin
        x_cur = wet[r_ch];
        x_neg = -{x_cur[23], x_cur};
        x_mag = x_cur[23] ? x_neg[23:0] : x_cur[23:0];
    end

    // saturation of the finished aux product
    always_comb begin
        p_sat = prod_u[57:16];
        if (r_sneg) begin
            sat_val = (p_sat > SAT_NEG) ? 24'sh800000 : $signed(24'(-p_sat[23:0]));
        end else begin
            sat_val = (p_sat > SAT_POS) ? 24'sh7FFFFF : $signed(p_sat[23:0]);
        end
        st_idx = (r_state == ST_LAST) ? CH_LAST : (r_ch - CH_W'(1));
    end

    // operand selection for the shared multiplier
    always_comb begin
        alpha_sel = (r_state == ST_MMHI || r_state == ST_MMLO) ? ma : ga;
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_MMHI, ST_GMHI: begin
                mul_a = $signed({11'd0, r_mag[41:24]});
                mul_b = $signed({4'd0, alpha_sel});
            end
            ST_MMLO, ST_GMLO: begin
                mul_a = $signed({5'd0, r_mag[23:0]});
                mul_b = $signed({4'd0, alpha_sel});
            end
            ST_YLO: begin
                mul_a = $signed({5'd0, r_gain_s[23:0]});
                mul_b = $signed({7'd0, LOG2_10_OVER_20});
            end
            ST_YHI: begin
                mul_a = $signed({{12{r_gain_s[STATE_W-1]}}, r_gain_s[STATE_W-1:24]});
                mul_b = $signed({7'd0, LOG2_10_OVER_20});
            end
            ST_INTERP: begin
                mul_a = $signed({7'd0, lut_d});
                mul_b = $signed({13'd0, r_w});
            end
            ST_CHA: begin
                mul_a = $signed({5'd0, x_mag});
                mul_b = $signed({4'd0, r_gain});
            end
            ST_CHB: begin
                mul_a = $signed(prod_u[48:20]);
                mul_b = $signed({12'd0, r_mix_s[STATE_W-1:24]});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    smgos_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_p)
    );

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (in_acc) n_state = ST_MDIFF;
            ST_MDIFF:  n_state = ST_MMHI;
            ST_MMHI:   n_state = ST_MMLO;
            ST_MMLO:   n_state = ST_MUPD;
            ST_MUPD:   n_state = ST_GDIFF;
            ST_GDIFF:  n_state = ST_GMHI;
            ST_GMHI:   n_state = ST_GMLO;
            ST_GMLO:   n_state = ST_GUPD;
            ST_GUPD:   n_state = ST_YLO;
            ST_YLO:    n_state = ST_YHI;
            ST_YHI:    n_state = ST_YSUM;
            ST_YSUM:   n_state = ST_INTERP;
            ST_INTERP: n_state = ST_GAIN;
            ST_GAIN:   n_state = ST_CHA;
            ST_CHA:    n_state = ST_CHB;
            ST_CHB:    n_state = (r_ch == CH_LAST) ? ST_LAST : ST_CHA;
            ST_LAST:   n_state = ST_DONE;
            ST_DONE:   if (out_load) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // control state, configuration and smoother state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_mix_alpha  <= ALPHA_ONE;
            r_gain_alpha <= ALPHA_ONE;
            r_active     <= ACT_RESET;
            r_mix_s      <= STATE_W'(1) << 40;
            r_gain_s     <= '0;
            r_ch         <= '0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MIX_ALPHA:  r_mix_alpha  <= i_cfg_data;
                    CFG_GAIN_ALPHA: r_gain_alpha <= i_cfg_data;
                    CFG_ACTIVE:     r_active     <= i_cfg_data[ACT_W-1:0];
                    default:        ;
                endcase
            end
            if (r_state == ST_MUPD) begin
                r_mix_s <= r_neg ? r_mix_s - step[STATE_W-1:0]
                                 : r_mix_s + step[STATE_W-1:0];
            end
            if (r_state == ST_GUPD) begin
                r_gain_s <= r_neg ? r_gain_s - $signed(step[STATE_W-1:0])
                                  : r_gain_s + $signed(step[STATE_W-1:0]);
            end
            if (r_state == ST_GAIN) begin
                r_ch <= '0;
            end else if (r_state == ST_CHB) begin
                r_ch <= r_ch + CH_W'(1);
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_data;
        end
        if (r_state == ST_MDIFF || r_state == ST_GDIFF) begin
            r_mag <= mag;
            r_neg <= diff[42];
        end
        if (r_state == ST_MMLO || r_state == ST_GMLO || r_state == ST_YHI) begin
            r_acc <= prod_u;
        end
        if (r_state == ST_YSUM) begin
            r_n <= u_sum[60:56];
            r_i <= u_sum[55:52];
            r_w <= u_sum[51:36];
        end
        if (r_state == ST_GAIN) begin
            r_gain <= gain_sh[24:0];
        end
        if (r_state == ST_CHB) begin
            r_sneg <= x_cur[23];
        end
        if ((r_state == ST_CHA && r_ch != '0) || r_state == ST_LAST) begin
            r_aux[st_idx] <= sat_val;
        end
        // result register with inactive channels forced to zero
        if (out_load) begin
            r_out.main_left  <= (r_active > 4'd0) ? r_in.dry_left : '0;
            r_out.main_right <= (r_active > 4'd1) ? r_in.dry_right : '0;
            r_out.aux_out_0  <= (r_active > 4'd2) ? r_aux[0] : '0;
            r_out.aux_out_1  <= (r_active > 4'd3) ? r_aux[1] : '0;
            r_out.aux_out_2  <= (r_active > 4'd4) ? r_aux[2] : '0;
            r_out.aux_out_3  <= (r_active > 4'd5) ? r_aux[3] : '0;
            r_out.aux_out_4  <= (r_active > 4'd6) ? r_aux[4] : '0;
            r_out.aux_out_5  <= (r_active > 4'd7) ? r_aux[5] : '0;
            r_out.aux_out_6  <= (r_active > 4'd8) ? r_aux[6] : '0;
            r_out.aux_out_7  <= (r_active > 4'd9) ? r_aux[7] : '0;
        end
    end

endmodule

### rtl/smgos_checker.sv
module smgos_checker
    import smgos_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    // a taken request makes the block busy
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input still ready right after a request");

    // a new result appears only as the sequencer returns to idle
    a_result_at_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("result appeared while the block was busy");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result dropped or changed");

    // reset leaves the block idle with nothing pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("block not idle after reset");

endmodule

bind smoothed_mix_gain_output_stage_core smgos_checker u_smgos_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

### sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import smgos_pkg::*;

    localparam int RANDOM_ITEMS   = 1400;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 40;
    localparam int LANES_W        = OUT_CHANNELS * SAMPLE_BITS;
    localparam logic signed [23:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] SAMPLE_MIN = 24'sh800000;
    localparam logic [24:0] ALPHA_TOP = 25'h1FFFFFF;

    typedef enum {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_LIGHT} stall_mode_e;

    // expected frames and a bit-exact copy of the smoothing and gain math
    class output_stage_scoreboard;
        t_out        pending_outputs[$];
        int          errors;
        logic [24:0] mix_alpha;
        logic [24:0] gain_alpha;
        logic [3:0]  active_count;
        longint      mix_level;
        longint      gain_db_level;
        longint      pow2_q20[17];
        string       lane_names[OUT_CHANNELS];

        function new();
            errors        = 0;
            mix_alpha     = ALPHA_ONE;
            gain_alpha    = ALPHA_ONE;
            active_count  = ACT_RESET;
            mix_level     = longint'(1) << 40;
            gain_db_level = 0;
            pow2_q20 = '{1048576, 1095000, 1143480, 1194106, 1246974, 1302182,
                         1359835, 1420040, 1482910, 1548564, 1617125, 1688722,
                         1763488, 1841564, 1923097, 2008240, 2097152};
            lane_names = '{"main_left", "main_right", "aux_out_0", "aux_out_1",
                           "aux_out_2", "aux_out_3", "aux_out_4", "aux_out_5",
                           "aux_out_6", "aux_out_7"};
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MIX_ALPHA:  mix_alpha = data;
                CFG_GAIN_ALPHA: gain_alpha = data;
                CFG_ACTIVE:     active_count = data[ACT_W-1:0];
                default: ;
            endcase
        endfunction

        // one-pole step, truncated toward the old value so it never overshoots
        function longint smooth_step(longint level, longint goal, longint unsigned a);
            longint diff;
            longint unsigned mag, stride;
            diff   = goal - level;
            mag    = (diff < 0) ? -diff : diff;
            stride = (mag >> 24) * a + (((mag & 64'hFFFFFF) * a) >> 24);
            return (diff < 0) ? level - longint'(stride) : level + longint'(stride);
        endfunction

        // Q8.32 dB to Q4.20 linear gain through the interpolated 2^x table
        function longint unsigned level_to_gain(longint g);
            longint unsigned u, w, mant;
            int n, seg;
            u    = g * 2786635 + (longint'(16) << 56);
            n    = int'((u >> 56) & 31);
            seg  = int'((u >> 52) & 15);
            w    = (u >> 36) & 64'hFFFF;
            mant = pow2_q20[seg] + (((pow2_q20[seg+1] - pow2_q20[seg]) * w) >> 16);
            return (n >= 16) ? (mant << (n - 16)) : (mant >> (16 - n));
        endfunction

        // magnitude scaled, sign put back, saturated to the sample width
        function logic [23:0] scale_wet(logic signed [23:0] x, longint unsigned gain,
                                        longint unsigned wet16);
            longint xs, res;
            longint unsigned mag, prod, lim;
            xs   = x;
            lim  = longint'(1) << (SAMPLE_BITS - 1);
            mag  = (xs < 0) ? -xs : xs;
            prod = (((mag * gain) >> 20) * wet16) >> 16;
            if (xs < 0)
                res = (prod > lim) ? -longint'(lim) : -longint'(prod);
            else
                res = (prod > lim - 1) ? longint'(lim - 1) : longint'(prod);
            return res[23:0];
        endfunction

        function t_out predict_outputs(t_in f);
            longint unsigned ma, ga, mt, gain, wet16;
            longint gt;
            logic signed [23:0] wet[WET_CHANNELS];
            logic [23:0] lanes[OUT_CHANNELS];
            t_out r;
            ma = (mix_alpha > ALPHA_ONE) ? ALPHA_ONE : mix_alpha;
            ga = (gain_alpha > ALPHA_ONE) ? ALPHA_ONE : gain_alpha;
            mt = f.mix_target;
            if (mt > MIX_ONE)
                mt = MIX_ONE;
            gt = f.gain_db_target;
            if (gt < DB_MIN)
                gt = DB_MIN;
            if (gt > DB_MAX)
                gt = DB_MAX;
            mix_level     = smooth_step(mix_level, longint'(mt) << 24, ma);
            gain_db_level = smooth_step(gain_db_level, gt * (longint'(1) << 24), ga);
            gain  = level_to_gain(gain_db_level);
            wet16 = mix_level >> 24;
            wet = '{f.wet_in_0, f.wet_in_1, f.wet_in_2, f.wet_in_3,
                    f.wet_in_4, f.wet_in_5, f.wet_in_6, f.wet_in_7};
            lanes[0] = f.dry_left;
            lanes[1] = f.dry_right;
            for (int k = 0; k < WET_CHANNELS; k++)
                lanes[k+2] = scale_wet(wet[k], gain, wet16);
            // channels past the active count stay silent
            for (int k = 0; k < OUT_CHANNELS; k++)
                if (k >= active_count)
                    lanes[k] = '0;
            r = {lanes[0], lanes[1], lanes[2], lanes[3], lanes[4],
                 lanes[5], lanes[6], lanes[7], lanes[8], lanes[9]};
            return r;
        endfunction

        function void note_frame(t_in f);
            pending_outputs.push_back(predict_outputs(f));
        endfunction

        function void check_result(t_out got);
            logic [LANES_W-1:0] wb, gb;
            if (pending_outputs.size() == 0) begin
                $error("result request with no frame pending");
                errors++;
                return;
            end
            wb = pending_outputs.pop_front();
            gb = got;
            for (int k = 0; k < OUT_CHANNELS; k++) begin
                if (wb[LANES_W-1-SAMPLE_BITS*k -: SAMPLE_BITS] !==
                    gb[LANES_W-1-SAMPLE_BITS*k -: SAMPLE_BITS]) begin
                    $error("%s expected %0d actual %0d", lane_names[k],
                           $signed(wb[LANES_W-1-SAMPLE_BITS*k -: SAMPLE_BITS]),
                           $signed(gb[LANES_W-1-SAMPLE_BITS*k -: SAMPLE_BITS]));
                    errors++;
                end
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in                   i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out                  o_out_data;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    output_stage_scoreboard board;
    int               burst_left;
    int               idle_cycles;
    bit               hold_off_req;
    logic [16:0]      mix_goal;
    logic signed [15:0] db_goal;

    smoothed_mix_gain_output_stage_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // request monitor, register tracking and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                board.write_reg(i_cfg_idx, i_cfg_data);
            if (i_in_valid && o_in_ready)
                board.note_frame(i_in_data);
            if (o_out_valid && i_out_ready)
                board.check_result(o_out_data);
        end
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver stall pattern, with one long hold-off on demand
    initial begin : receiver
        stall_mode_e mode;
        int span, hold_left;
        mode = STALL_NONE;
        span = 0;
        hold_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left = HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else begin
                if (span == 0) begin
                    mode = stall_mode_e'($urandom_range(0, 3));
                    span = $urandom_range(20, 300);
                end
                span--;
                case (mode)
                    STALL_NONE:  i_out_ready <= 1'b1;
                    STALL_HALF:  i_out_ready <= 1'($urandom_range(0, 1));
                    STALL_HEAVY: i_out_ready <= ($urandom_range(0, 7) == 0);
                    default:     i_out_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    function automatic t_in frame_of(logic signed [23:0] dry, wet_even, wet_odd,
                                     logic [16:0] mix, logic signed [15:0] db);
        t_in f;
        f.dry_left       = dry;
        f.dry_right      = ~dry;
        f.mix_target     = mix;
        f.gain_db_target = db;
        f.wet_in_0 = wet_even;
        f.wet_in_1 = wet_odd;
        f.wet_in_2 = wet_even;
        f.wet_in_3 = wet_odd;
        f.wet_in_4 = wet_even;
        f.wet_in_5 = wet_odd;
        f.wet_in_6 = wet_even;
        f.wet_in_7 = wet_odd;
        return f;
    endfunction

    function automatic logic signed [23:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return '0;
            3:       return 24'(int'($urandom_range(0, 512)) - 256);
            default: return 24'($urandom);
        endcase
    endfunction

    // targets mostly stick for a while so the smoothers can settle
    function automatic t_in random_frame();
        t_in f;
        if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 9))
                0:       mix_goal = '0;
                1:       mix_goal = MIX_ONE;
                2:       mix_goal = 17'($urandom);
                default: mix_goal = 17'($urandom_range(0, MIX_ONE));
            endcase
        end
        if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 9))
                0:       db_goal = DB_MIN;
                1:       db_goal = DB_MAX;
                2:       db_goal = 16'($urandom);
                3:       db_goal = 16'(int'($urandom_range(0, 1024)) - 512);
                default: db_goal = 16'(int'($urandom_range(0, 30720)) - 24576);
            endcase
        end
        f.dry_left       = rand_sample();
        f.dry_right      = rand_sample();
        f.mix_target     = mix_goal;
        f.gain_db_target = db_goal;
        f.wet_in_0 = rand_sample();
        f.wet_in_1 = rand_sample();
        f.wet_in_2 = rand_sample();
        f.wet_in_3 = rand_sample();
        f.wet_in_4 = rand_sample();
        f.wet_in_5 = rand_sample();
        f.wet_in_6 = rand_sample();
        f.wet_in_7 = rand_sample();
        return f;
    endfunction

    function automatic logic [24:0] random_alpha();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 25'($urandom_range(1, 16));
            2:       return 25'($urandom_range(1, 65536));
            3:       return ALPHA_ONE;
            4:       return 25'($urandom_range(ALPHA_ONE, ALPHA_TOP));
            5:       return 25'($urandom);
            default: return 25'($urandom_range(0, ALPHA_ONE));
        endcase
    endfunction

    function automatic logic [3:0] random_active();
        if ($urandom_range(0, 2) == 0)
            return ACT_RESET;
        return 4'($urandom_range(0, 15));
    endfunction

    // offer one frame, with bursts and gaps between them
    task automatic send_frame(input t_in f);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) == 0)
                burst_left = $urandom_range(40, 120);
            else
                burst_left = $urandom_range(1, 8);
            if ($urandom_range(0, 4) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 50)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= f;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
    endtask

    // stop offering and wait for every expected result
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending_outputs.size() != 0)
            @(posedge i_clk);
    endtask

    // write all three registers while the block is idle
    task automatic program_regs(input logic [24:0] mix_a, input logic [24:0] gain_a,
                                input logic [3:0] act);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_MIX_ALPHA;
        i_cfg_data <= mix_a;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_GAIN_ALPHA;
        i_cfg_data <= gain_a;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_ACTIVE;
        i_cfg_data <= CFG_DATA_W'(act);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin : stimulus
        int done_items, phase_len;
        board        = new();
        burst_left   = 0;
        idle_cycles  = 0;
        hold_off_req = 1'b0;
        mix_goal     = MIX_ONE;
        db_goal      = '0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_MIX_ALPHA;
        i_cfg_data <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: saturation both ways, clamped targets, unity and mute
        send_frame(frame_of(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, MIX_ONE, DB_MAX));
        send_frame(frame_of(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, MIX_ONE, DB_MAX));
        send_frame(frame_of(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, 17'h1FFFF, 16'sh7FFF));
        send_frame(frame_of(24'sd0, 24'sd1, -24'sd1, 17'd0, 16'sh8000));
        send_frame(frame_of(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, 17'd0, DB_MIN));
        send_frame(frame_of(24'sd12345, 24'sd4096, -24'sd4096, 17'd32768, 16'sd0));
        send_frame(frame_of(-24'sd1, 24'sd100000, -24'sd100000, 17'd65535, DB_MIN));
        send_frame(frame_of(24'sd0, 24'sd0, 24'sd0, 17'd0, 16'sd0));
        drain_results();

        // alpha above one, frozen gain, nothing active
        program_regs(ALPHA_TOP, '0, 4'd0);
        send_frame(frame_of(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, 17'd20000, 16'sd3000));
        send_frame(frame_of(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX, MIX_ONE, DB_MAX));
        drain_results();

        // frozen mix, gain above one, only main left
        program_regs('0, ALPHA_TOP, 4'd1);
        send_frame(frame_of(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, 17'd0, DB_MAX));
        send_frame(frame_of(24'sd777, 24'sd5000, -24'sd5000, MIX_ONE, -16'sd2560));
        drain_results();

        // slow tracking, mains only
        program_regs(ALPHA_ONE >> 3, ALPHA_ONE >> 5, 4'd2);
        send_frame(frame_of(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, 17'd0, DB_MIN));
        send_frame(frame_of(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, 17'd0, DB_MIN));
        send_frame(frame_of(24'sd3, SAMPLE_MAX, SAMPLE_MIN, MIX_ONE, DB_MAX));
        drain_results();

        // smallest alpha, active count above ten
        program_regs(25'd1, 25'd1, 4'd15);
        send_frame(frame_of(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, 17'd0, DB_MIN));
        send_frame(frame_of(SAMPLE_MIN, 24'sd65536, -24'sd65536, 17'd0, DB_MAX));
        drain_results();

        // immediate tracking, last aux off
        program_regs(ALPHA_ONE, ALPHA_ONE, 4'd9);
        send_frame(frame_of(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, MIX_ONE, DB_MAX));
        send_frame(frame_of(SAMPLE_MIN, 24'sd1000, -24'sd1000, 17'd40000, -16'sd1536));
        drain_results();

        // random phases, each under its own register settings
        done_items = 0;
        while (done_items < RANDOM_ITEMS) begin
            program_regs(random_alpha(), random_alpha(), random_active());
            phase_len = $urandom_range(60, 250);
            for (int k = 0; k < phase_len && done_items < RANDOM_ITEMS; k++) begin
                if (done_items == 40) begin
                    // receiver holds off while the sender keeps offering
                    hold_off_req = 1'b1;
                    burst_left = 30;
                end
                send_frame(random_frame());
                done_items++;
            end
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### files.f
rtl/smgos_pkg.sv
rtl/smgos_mul.sv
rtl/smoothed_mix_gain_output_stage_core.sv
rtl/smgos_checker.sv
sim/tb.sv
